FILE: rtl/sbus_frame_decoder_assert.svh
// Assertion macros used by the frame decoder unpacker.
`ifndef SBUS_FRAME_DECODER_ASSERT_SVH
`define SBUS_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/sfd_pkg.sv
// Shared constants and interface types of the frame decoder.
package sfd_pkg;

   localparam int ADDR_W  = 5;
   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 11;
   localparam int CH_W    = 4;
   localparam int FLAG_W  = 4;
   localparam int NBITS_W = 5;
   // accumulator holds fewer than 11 bits plus one byte
   localparam int ACC_W   = VALUE_W + BYTE_W;

   localparam int FRAME_DEPTH = 25;

   localparam logic [BYTE_W-1:0] START_BYTE         = 8'h0F;
   localparam logic [ADDR_W-1:0] FRAME_BYTES        = 5'd25;
   localparam logic [ADDR_W-1:0] LAST_POS           = 5'd24;
   localparam logic [ADDR_W-1:0] FLAG_ADDR          = 5'd23;
   localparam logic [ADDR_W-1:0] FIRST_PAYLOAD_ADDR = 5'd1;
   localparam logic [CH_W-1:0]   LAST_CH            = 4'd15;
   localparam logic [NBITS_W-1:0] VALUE_BITS        = 5'd11;
   localparam logic [NBITS_W-1:0] BYTE_BITS         = 5'd8;

   // flag byte bit positions
   localparam int FLAG_CH17     = 0;
   localparam int FLAG_CH18     = 1;
   localparam int FLAG_LOST     = 2;
   localparam int FLAG_FAILSAFE = 3;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
   } ram_wr_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_rd_type;

endpackage

FILE: rtl/sbus_frame_decoder.sv
// Serial receiver frame decoder: 25-byte frame in, 16 channel words out.
//
// Input channel (req_): one received serial byte per word. While waiting for
// a frame, any byte other than the start byte 0x0F is dropped. The start byte
// and the 24 bytes after it go into a 25-entry frame store; the end byte is
// not checked and there is no timeout between bytes.
// Result channel (rsp_): after the 25th byte, 16 words, channel 0 first, each
// with its 11-bit value and the four flags of byte 23; the last has
// rsp_last_of_frame set.
// Flow control: req_ready is high only while the unpacker is idle. After the
// closing byte the unpacker reads the flag byte, then reads the 22 payload
// bytes through its single read port into a bit accumulator and emits the 16
// words, and req_ready stays low until the last word is loaded. A stalled
// rsp_ready holds the output register and pauses the unpacker, which keeps
// req_ready low for as long as the stall lasts.
// Reset: synchronous, active high; clears the byte position and the unpacker
// state. The frame store is not cleared; every entry is written before use.
module sbus_frame_decoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sfd_pkg::BYTE_W-1:0]      req_received_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sfd_pkg::CH_W-1:0]        rsp_channel_index,
   output logic [sfd_pkg::VALUE_W-1:0]     rsp_channel_value,
   output logic                            rsp_digital_ch17,
   output logic                            rsp_digital_ch18,
   output logic                            rsp_signal_lost,
   output logic                            rsp_failsafe_active,
   output logic                            rsp_last_of_frame
);

   logic [sfd_pkg::ADDR_W-1:0]  pos_ff, pos_in;
   logic                        accept;
   logic                        start;
   logic                        busy;
   sfd_pkg::ram_wr_type         wr;
   sfd_pkg::ram_rd_type         rd;
   logic [sfd_pkg::BYTE_W-1:0]  rd_data;

   // hold off input words while a frame is being unpacked
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   // track the byte position and write frame bytes
   always_comb begin
      pos_in     = pos_ff;
      start      = 1'b0;
      wr.wr_en   = 1'b0;
      wr.wr_addr = pos_ff;
      wr.wr_data = req_received_byte;
      if (accept) begin
         if (pos_ff == '0) begin
            if (req_received_byte == sfd_pkg::START_BYTE) begin
               wr.wr_en = 1'b1;
               pos_in   = 5'd1;
            end
         end else if (pos_ff >= sfd_pkg::FRAME_BYTES) begin
            pos_in = '0;
         end else begin
            wr.wr_en = 1'b1;
            if (pos_ff == sfd_pkg::LAST_POS) begin
               pos_in = '0;
               start  = 1'b1;
            end else begin
               pos_in = pos_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   sfd_frame_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   sfd_unpacker u_unpack (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .rd                  (rd),
      .rd_data             (rd_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_digital_ch17    (rsp_digital_ch17),
      .rsp_digital_ch18    (rsp_digital_ch18),
      .rsp_signal_lost     (rsp_signal_lost),
      .rsp_failsafe_active (rsp_failsafe_active),
      .rsp_last_of_frame   (rsp_last_of_frame)
   );

endmodule

FILE: rtl/sfd_frame_ram.sv
// Frame byte store: one write port, one read port with registered data.
module sfd_frame_ram (
   input  logic                         clock,
   input  sfd_pkg::ram_wr_type          wr,
   input  sfd_pkg::ram_rd_type          rd,
   output logic [sfd_pkg::BYTE_W-1:0]   rd_data
);

   logic [sfd_pkg::BYTE_W-1:0] store_ff [sfd_pkg::FRAME_DEPTH];
   logic [sfd_pkg::BYTE_W-1:0] rd_data_ff;

   // write one byte
   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         store_ff[wr.wr_addr] <= wr.wr_data;
      end
   end

   // read one byte, data valid the next cycle
   always_ff @(posedge clock) begin
      if (rd.rd_en) begin
         rd_data_ff <= store_ff[rd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sfd_unpacker.sv
// Channel unpacker: streams payload bytes into a bit accumulator, emits 11-bit channel words.
`include "sbus_frame_decoder_assert.svh"

module sfd_unpacker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   output sfd_pkg::ram_rd_type             rd,
   input  logic [sfd_pkg::BYTE_W-1:0]      rd_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sfd_pkg::CH_W-1:0]        rsp_channel_index,
   output logic [sfd_pkg::VALUE_W-1:0]     rsp_channel_value,
   output logic                            rsp_digital_ch17,
   output logic                            rsp_digital_ch18,
   output logic                            rsp_signal_lost,
   output logic                            rsp_failsafe_active,
   output logic                            rsp_last_of_frame
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_FLAG = 4'b0010,
      ST_LOAD = 4'b0100,
      ST_EMIT = 4'b1000
   } unpack_state_type;

   unpack_state_type                 state_ff, state_in;
   logic [sfd_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [sfd_pkg::ACC_W-1:0]        acc_ff, acc_in;
   logic [sfd_pkg::NBITS_W-1:0]      nbits_ff, nbits_in;
   logic [sfd_pkg::CH_W-1:0]         ch_ff, ch_in;
   logic [sfd_pkg::FLAG_W-1:0]       flags_ff, flags_in;
   logic                             out_valid_ff, out_valid_in;
   logic [sfd_pkg::CH_W-1:0]         out_ch_ff;
   logic [sfd_pkg::VALUE_W-1:0]      out_value_ff;
   logic [sfd_pkg::FLAG_W-1:0]       out_flags_ff;
   logic                             out_last_ff;
   logic                             out_free;
   logic                             out_load;
   logic [sfd_pkg::NBITS_W-1:0]      nbits_left;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign nbits_left = nbits_ff - sfd_pkg::VALUE_BITS;

   // sequence reads, accumulate bits, emit channel words
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      acc_in     = acc_ff;
      nbits_in   = nbits_ff;
      ch_in      = ch_ff;
      flags_in   = flags_ff;
      rd.rd_en   = 1'b0;
      rd.rd_addr = addr_ff;
      out_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rd.rd_en   = 1'b1;
               rd.rd_addr = sfd_pkg::FLAG_ADDR;
               state_in   = ST_FLAG;
            end
         end
         ST_FLAG: begin
            flags_in   = rd_data[sfd_pkg::FLAG_W-1:0];
            rd.rd_en   = 1'b1;
            rd.rd_addr = sfd_pkg::FIRST_PAYLOAD_ADDR;
            addr_in    = sfd_pkg::FIRST_PAYLOAD_ADDR + 5'd1;
            acc_in     = '0;
            nbits_in   = '0;
            ch_in      = '0;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            acc_in   = acc_ff | ({{sfd_pkg::VALUE_W{1'b0}}, rd_data} << nbits_ff);
            nbits_in = nbits_ff + sfd_pkg::BYTE_BITS;
            if (nbits_ff + sfd_pkg::BYTE_BITS >= sfd_pkg::VALUE_BITS) begin
               state_in = ST_EMIT;
            end else begin
               rd.rd_en = 1'b1;
               addr_in  = addr_ff + 5'd1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               acc_in   = acc_ff >> sfd_pkg::VALUE_W;
               nbits_in = nbits_left;
               ch_in    = ch_ff + 4'd1;
               if (ch_ff == sfd_pkg::LAST_CH) begin
                  state_in = ST_IDLE;
               end else if (nbits_left < sfd_pkg::VALUE_BITS) begin
                  rd.rd_en = 1'b1;
                  addr_in  = addr_ff + 5'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: load on emit, drop when taken
   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      acc_ff   <= acc_in;
      nbits_ff <= nbits_in;
      ch_ff    <= ch_in;
      flags_ff <= flags_in;
      if (out_load) begin
         out_ch_ff    <= ch_ff;
         out_value_ff <= acc_ff[sfd_pkg::VALUE_W-1:0];
         out_flags_ff <= flags_ff;
         out_last_ff  <= (ch_ff == sfd_pkg::LAST_CH);
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = out_valid_ff;
   assign rsp_channel_index   = out_ch_ff;
   assign rsp_channel_value   = out_value_ff;
   assign rsp_digital_ch17    = out_flags_ff[sfd_pkg::FLAG_CH17];
   assign rsp_digital_ch18    = out_flags_ff[sfd_pkg::FLAG_CH18];
   assign rsp_signal_lost     = out_flags_ff[sfd_pkg::FLAG_LOST];
   assign rsp_failsafe_active = out_flags_ff[sfd_pkg::FLAG_FAILSAFE];
   assign rsp_last_of_frame   = out_last_ff;

   // a decode starts only from idle
   `SFD_ASSERT_NOW(a_start_idle, clock, reset, start, state_ff == ST_IDLE, "start while busy")
   // read data consumed in LOAD was requested the cycle before
   `SFD_ASSERT_NOW(a_load_read, clock, reset, state_ff == ST_LOAD, $past(rd.rd_en),
                   "no read pending")
   // emitting needs a full channel word in the accumulator
   `SFD_ASSERT_NOW(a_emit_bits, clock, reset, state_ff == ST_EMIT,
                   nbits_ff >= sfd_pkg::VALUE_BITS, "short accumulator")
   // reads never run past the payload into the flag byte
   `SFD_ASSERT_NOW(a_rd_range, clock, reset, rd.rd_en && state_ff != ST_IDLE,
                   rd.rd_addr < sfd_pkg::FLAG_ADDR, "payload read out of range")

endmodule

FILE: test/sbus_frame_decoder_check.sv
// Checker for the frame decoder: tracks accepted bytes, predicts channel words, compares.
module sbus_frame_decoder_check (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [sfd_pkg::BYTE_W-1:0]           req_received_byte,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [sfd_pkg::CH_W-1:0]             rsp_channel_index,
   input  logic [sfd_pkg::VALUE_W-1:0]          rsp_channel_value,
   input  logic                                 rsp_digital_ch17,
   input  logic                                 rsp_digital_ch18,
   input  logic                                 rsp_signal_lost,
   input  logic                                 rsp_failsafe_active,
   input  logic                                 rsp_last_of_frame,
   output int                                   mismatch_count,
   output int                                   words_due
);

   localparam int PAYLOAD_BYTES = 22;
   localparam int CHANNELS      = 16;

   typedef struct packed {
      logic [sfd_pkg::CH_W-1:0]    index;
      logic [sfd_pkg::VALUE_W-1:0] value;
      logic                        ch17;
      logic                        ch18;
      logic                        lost;
      logic                        failsafe;
      logic                        last;
   } channel_word_type;

   // predicted decoder state
   logic [sfd_pkg::ADDR_W-1:0] frame_pos;
   logic [sfd_pkg::BYTE_W-1:0] frame_bytes [0:sfd_pkg::FRAME_DEPTH-1];
   channel_word_type           channel_words_due [$];

   // Unpack the held frame into sixteen channel words.
   task automatic unpack_frame();
      logic [8*PAYLOAD_BYTES-1:0] payload;
      logic [sfd_pkg::BYTE_W-1:0] flags;
      channel_word_type           w;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         payload[8*i +: 8] = frame_bytes[1 + i];
      end
      flags = frame_bytes[sfd_pkg::FLAG_ADDR];
      for (int ch = 0; ch < CHANNELS; ch++) begin
         w.index    = ch[sfd_pkg::CH_W-1:0];
         w.value    = payload[11*ch +: 11];
         w.ch17     = flags[sfd_pkg::FLAG_CH17];
         w.ch18     = flags[sfd_pkg::FLAG_CH18];
         w.lost     = flags[sfd_pkg::FLAG_LOST];
         w.failsafe = flags[sfd_pkg::FLAG_FAILSAFE];
         w.last     = (w.index == sfd_pkg::LAST_CH);
         channel_words_due.push_back(w);
      end
   endtask

   // Advance the frame tracker by one accepted byte.
   task automatic absorb_byte(input logic [sfd_pkg::BYTE_W-1:0] rx);
      if (frame_pos == '0) begin
         if (rx == sfd_pkg::START_BYTE) begin
            frame_bytes[0] = rx;
            frame_pos = sfd_pkg::FIRST_PAYLOAD_ADDR;
         end
      end else begin
         frame_bytes[frame_pos] = rx;
         frame_pos = frame_pos + 5'd1;
         if (frame_pos == sfd_pkg::FRAME_BYTES) begin
            frame_pos = '0;
            unpack_frame();
         end
      end
   endtask

   task automatic check_field(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      channel_word_type w;
      if (reset) begin
         frame_pos = '0;
         channel_words_due.delete();
         mismatch_count = 0;
      end else begin
         // track accepted bytes
         if (req_valid && req_ready) begin
            absorb_byte(req_received_byte);
         end
         // compare accepted words with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (channel_words_due.size() == 0) begin
               $display("%0t: unexpected word, expected none, got channel %0d value %0d",
                        $time, rsp_channel_index, rsp_channel_value);
               mismatch_count++;
            end else begin
               w = channel_words_due.pop_front();
               check_field("channel_index", 32'(w.index), 32'(rsp_channel_index));
               check_field("channel_value", 32'(w.value), 32'(rsp_channel_value));
               check_field("digital_ch17", 32'(w.ch17), 32'(rsp_digital_ch17));
               check_field("digital_ch18", 32'(w.ch18), 32'(rsp_digital_ch18));
               check_field("signal_lost", 32'(w.lost), 32'(rsp_signal_lost));
               check_field("failsafe_active", 32'(w.failsafe), 32'(rsp_failsafe_active));
               check_field("last_of_frame", 32'(w.last), 32'(rsp_last_of_frame));
            end
         end
      end
      words_due = channel_words_due.size();
   end

endmodule

FILE: test/sbus_frame_decoder_test.sv
// Top of the frame decoder test: clock, reset, byte stimulus, receiver stalls and verdict.
module sbus_frame_decoder_test;

   localparam int PHASE_BYTES = 100;
   localparam int HOLD_CYCLES = 300;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [sfd_pkg::BYTE_W-1:0]   req_received_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [sfd_pkg::CH_W-1:0]     rsp_channel_index;
   logic [sfd_pkg::VALUE_W-1:0]  rsp_channel_value;
   logic                         rsp_digital_ch17;
   logic                         rsp_digital_ch18;
   logic                         rsp_signal_lost;
   logic                         rsp_failsafe_active;
   logic                         rsp_last_of_frame;

   int mismatch_count;
   int words_due;
   int send_idle_pct = 14;
   int recv_idle_pct = 73;
   bit hold_req  = 1'b0;
   bit hold_done = 1'b0;
   int frame_bytes_sent;

   sbus_frame_decoder uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_received_byte   (req_received_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_digital_ch17    (rsp_digital_ch17),
      .rsp_digital_ch18    (rsp_digital_ch18),
      .rsp_signal_lost     (rsp_signal_lost),
      .rsp_failsafe_active (rsp_failsafe_active),
      .rsp_last_of_frame   (rsp_last_of_frame)
   );

   sbus_frame_decoder_check u_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_received_byte   (req_received_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_digital_ch17    (rsp_digital_ch17),
      .rsp_digital_ch18    (rsp_digital_ch18),
      .rsp_signal_lost     (rsp_signal_lost),
      .rsp_failsafe_active (rsp_failsafe_active),
      .rsp_last_of_frame   (rsp_last_of_frame),
      .mismatch_count      (mismatch_count),
      .words_due           (words_due)
   );

   always #2 clock = ~clock;

   // Drive rsp_ready: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            repeat (HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
            hold_done = 1'b1;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one byte, idling at random first, and hold it until accepted.
   task automatic send_byte(input logic [sfd_pkg::BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_received_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Uniform random byte.
   function automatic logic [sfd_pkg::BYTE_W-1:0] rand_byte();
      int r;
      r = $urandom_range(255);
      return r[sfd_pkg::BYTE_W-1:0];
   endfunction

   // Payload byte biased toward the extremes.
   function automatic logic [sfd_pkg::BYTE_W-1:0] payload_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return rand_byte();
      endcase
   endfunction

   // Send a start byte and the rest of a frame, either filled or scrambled.
   task automatic send_frame(input bit scramble, input logic [sfd_pkg::BYTE_W-1:0] fill,
                             input logic [sfd_pkg::BYTE_W-1:0] flags,
                             input logic [sfd_pkg::BYTE_W-1:0] end_byte);
      send_byte(sfd_pkg::START_BYTE);
      for (int i = 1; i < int'(sfd_pkg::FLAG_ADDR); i++) begin
         send_byte(scramble ? payload_byte() : fill);
      end
      send_byte(flags);
      send_byte(end_byte);
   endtask

   // Mostly whole frames, with noise and cut-off frames mixed in.
   task automatic random_phase();
      int cut;
      frame_bytes_sent = 0;
      while (frame_bytes_sent < PHASE_BYTES) begin
         case ($urandom_range(9))
            0: begin
               repeat ($urandom_range(1, 4)) send_byte(rand_byte());
            end
            1: begin
               cut = $urandom_range(1, 23);
               send_byte(sfd_pkg::START_BYTE);
               repeat (cut) send_byte(payload_byte());
               frame_bytes_sent += cut + 1;
            end
            default: begin
               send_frame(1'b1, 8'h00, rand_byte(), rand_byte());
               frame_bytes_sent += int'(sfd_pkg::FRAME_BYTES);
            end
         endcase
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: dropped bytes while idle, then extreme frames
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h0E);
      send_byte(8'h10);
      // all-ones payload, every flag and the ignored flag bits set, end byte 0x00
      send_frame(1'b0, 8'hFF, 8'hFF, 8'h00);
      // start byte inside the frame as data, no flags, start byte as end byte
      send_frame(1'b0, sfd_pkg::START_BYTE, 8'hF0, sfd_pkg::START_BYTE);
      // alternating payload bits, lost-frame flag only
      send_frame(1'b0, 8'hAA, 8'h04, 8'h55);

      // random: sender idles lightly, receiver heavily
      random_phase();
      send_idle_pct = 73;
      recv_idle_pct = 14;
      random_phase();
      // no idling, with one long receiver hold-off to back up the input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req = 1'b1;
      random_phase();
      req_valid <= 1'b0;

      // drain, then let the unpacker settle
      @(negedge clock);
      while (words_due != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (mismatch_count == 0 && words_due == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Give up after a generous time.
   initial begin
      #800000;
      $display("Mismatches found");
      $finish;
   end

endmodule
